// ===== rtl/linear_interp_resampler_unit_assert.svh =====
// assertion macros for the linear interpolation resampler checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH

// implication into the next cycle, switched off while reset is held
`define LIRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lirs: assertion failed");

// implication into the next cycle, checked through reset as well
`define LIRS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("lirs: assertion failed");

`endif

// ===== rtl/lirs_pkg.sv =====
// shared constants and types for the linear interpolation resampler
// used by lirs_lane, lirs_seq and linear_interp_resampler_unit
package lirs_pkg;

    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int MAX_UPSAMPLE_DEF = 8;

    localparam int FRAC_BITS  = 24;
    localparam int F_BITS     = FRAC_BITS + 1;
    localparam int RATIO_BITS = 27;
    localparam int PHASE_BITS = 32;

    localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(1) << FRAC_BITS;

    localparam logic signed [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << FRAC_BITS;
    localparam logic signed [PHASE_BITS-1:0] PHASE_MIN = -PHASE_ONE;

    // apb register map
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 1;
    localparam logic [REG_IDX_BITS-1:0] REG_STEP_RATIO = 1'b0;
    localparam logic [REG_IDX_BITS-1:0] REG_MONO_INPUT = 1'b1;

    // per item controls from the sequencer to each channel lane
    typedef struct packed {
        logic              load;
        logic              restart;
        logic              commit;
        logic              issue;
        logic [F_BITS-1:0] frac;
    } t_lane_ctl;

endpackage

// ===== rtl/linear_interp_resampler_unit.sv =====
// Linear interpolation sample rate converter, top level.
// Slave stream: one frame per transaction, tdata holds left then right sample,
// tuser is the restart flag that clears phase and history before the frame.
// Master stream: interpolated frames, tlast on the final frame of each input.
// APB port: step_ratio at 0x0 (unsigned Q.24), mono_input at 0x4.
// Each input frame yields zero to MAX_UPSAMPLE output frames. After acceptance
// the slave side stays busy until the sequencer has walked every output position
// of that frame; one phase accumulator feeding both channel lanes gives one
// output position per cycle while the master side does not stall.
// The first result reaches the master side through the sequencer state register,
// the lane multiply register, then the output register.
// Reset clears phase, history, the output valid flag and the configuration to
// step_ratio = 1.0, stereo. A stall on the master side freezes the phase
// walk and the lane pipeline; nothing is dropped.
module linear_interp_resampler_unit
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF,
    localparam int DATA_BITS   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [DATA_BITS-1:0]     s_axis_tdata,   // sample_left, sample_right
    input  logic                     s_axis_tuser,   // restart
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [DATA_BITS-1:0]     m_axis_tdata,   // out_left, out_right
    output logic                     m_axis_tlast,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [RATIO_BITS-1:0]         r_step_ratio;
    logic                          r_mono;
    logic                          r_s1_valid;
    logic                          r_s1_last;
    logic                          r_out_valid;
    logic                          r_out_last;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;

    logic                          w_cfg_wr;
    logic [REG_IDX_BITS-1:0]       w_reg_idx;
    logic                          w_accept;
    logic                          w_advance;
    logic                          w_last;
    logic signed [SAMPLE_BITS-1:0] w_in_left;
    logic signed [SAMPLE_BITS-1:0] w_in_right;
    logic signed [SAMPLE_BITS-1:0] w_res_left;
    logic signed [SAMPLE_BITS-1:0] w_res_right;
    t_lane_ctl                     w_ctl;

    // configuration
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[APB_ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ratio <= RATIO_RESET;
            r_mono       <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_STEP_RATIO: r_step_ratio <= pwdata[RATIO_BITS-1:0];
                REG_MONO_INPUT: r_mono       <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_STEP_RATIO: prdata = APB_DATA_BITS'(r_step_ratio);
            REG_MONO_INPUT: prdata = APB_DATA_BITS'(r_mono);
            default:        prdata = '0;
        endcase
    end

    // input frame; mono copies channel zero into both lanes
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_in_left  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_in_right = r_mono ? w_in_left : s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // whole pipeline moves only when the output register can take a frame
    assign w_advance = !r_out_valid || m_axis_tready;

    lirs_seq #(
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_restart    (s_axis_tuser),
        .i_step_ratio (r_step_ratio),
        .i_advance    (w_advance),
        .o_ready      (s_axis_tready),
        .o_ctl        (w_ctl),
        .o_last       (w_last)
    );

    lirs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (w_in_left),
        .o_result (w_res_left)
    );

    lirs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (w_in_right),
        .o_result (w_res_right)
    );

    // merge the lane results into one output frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid  <= w_ctl.issue;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.issue) begin
            r_s1_last <= w_last;
        end
        if (w_advance) begin
            r_out_last  <= r_s1_last;
            r_out_left  <= w_res_left;
            r_out_right <= w_res_right;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = DATA_BITS'({r_out_right, r_out_left});

endmodule

// ===== rtl/lirs_lane.sv =====
// one channel lane: holds previous and current sample, multiplies the
// difference by the fraction and rounds; depends on lirs_pkg
module lirs_lane
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + F_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [SAMPLE_BITS-1:0] r_cur;
    logic signed [SAMPLE_BITS-1:0] r_base;
    logic signed [PROD_BITS-1:0]   r_prod;

    logic signed [DIFF_BITS-1:0]   w_diff;
    logic signed [F_BITS:0]        w_frac;
    logic signed [PROD_BITS-1:0]   w_prod;
    logic signed [PROD_BITS-1:0]   w_round;
    logic signed [PROD_BITS-1:0]   w_shift;

    assign w_diff = {r_cur[SAMPLE_BITS-1], r_cur} - {r_prev[SAMPLE_BITS-1], r_prev};
    assign w_frac = $signed({1'b0, i_ctl.frac});
    assign w_prod = w_diff * w_frac;

    // round half up, then floor by the fraction width
    assign w_round  = r_prod + (PROD_BITS'(1) << (FRAC_BITS - 1));
    assign w_shift  = w_round >>> FRAC_BITS;
    assign o_result = r_base + $signed(w_shift[SAMPLE_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_ctl.load && i_ctl.restart) begin
            r_prev <= '0;
        end else if (i_ctl.commit) begin
            r_prev <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cur <= i_sample;
        end
        if (i_ctl.issue) begin
            r_prod <= w_prod;
            r_base <= r_prev;
        end
    end

endmodule

// ===== rtl/lirs_seq.sv =====
// phase sequencer: walks the output positions of one input frame and
// drives both lanes; depends on lirs_pkg
module lirs_seq
    import lirs_pkg::*;
#(
    parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_restart,
    input  logic [RATIO_BITS-1:0] i_step_ratio,
    input  logic                  i_advance,
    output logic                  o_ready,
    output t_lane_ctl             o_ctl,
    output logic                  o_last
);

    localparam int CNT_BITS = $clog2(MAX_UPSAMPLE + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                         r_state, n_state;
    logic signed [PHASE_BITS-1:0] r_pos, n_pos;
    logic [CNT_BITS-1:0]          r_cnt, n_cnt;
    logic                         r_have, n_have;

    logic signed [PHASE_BITS-1:0] w_pos_inc;
    logic signed [PHASE_BITS-1:0] w_end_base;
    logic signed [PHASE_BITS-1:0] w_end_dec;
    logic signed [PHASE_BITS-1:0] w_end_pos;
    logic signed [PHASE_BITS-1:0] w_frac_full;
    logic [CNT_BITS-1:0]          w_cnt_inc;
    logic                         w_ok;
    logic                         w_last;
    logic                         w_issue;
    logic                         w_finish;

    function automatic logic emit_ok(
        input logic signed [PHASE_BITS-1:0] p,
        input logic [CNT_BITS-1:0]          c,
        input logic                         have
    );
        logic in_window;
        in_window = (p >= PHASE_MIN) && (p <= 0);
        return (c < CNT_BITS'(MAX_UPSAMPLE)) && in_window && ((p == 0) || have);
    endfunction

    assign w_pos_inc   = r_pos + $signed({{(PHASE_BITS - RATIO_BITS){1'b0}}, i_step_ratio});
    assign w_cnt_inc   = r_cnt + CNT_BITS'(1);
    assign w_ok        = emit_ok(r_pos, r_cnt, r_have);
    assign w_last      = !emit_ok(w_pos_inc, w_cnt_inc, r_have);
    assign w_issue     = (r_state == ST_RUN) && w_ok && i_advance;
    assign w_finish    = (r_state == ST_RUN) && (!w_ok || (w_issue && w_last));

    // end of frame: step back by one input period, never further than one behind
    assign w_end_base  = w_ok ? w_pos_inc : r_pos;
    assign w_end_dec   = w_end_base - PHASE_ONE;
    assign w_end_pos   = (w_end_dec < PHASE_MIN) ? PHASE_MIN : w_end_dec;
    assign w_frac_full = r_pos + PHASE_ONE;

    assign o_ready       = (r_state == ST_IDLE);
    assign o_last        = w_last;
    assign o_ctl.load    = i_accept;
    assign o_ctl.restart = i_restart;
    assign o_ctl.commit  = w_finish;
    assign o_ctl.issue   = w_issue;
    assign o_ctl.frac    = w_frac_full[F_BITS-1:0];

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_have  = r_have;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                    if (i_restart) begin
                        n_pos  = '0;
                        n_have = 1'b0;
                    end
                end
            end
            ST_RUN: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                    n_pos   = w_end_pos;
                    n_have  = 1'b1;
                end else if (w_issue) begin
                    n_pos = w_pos_inc;
                    n_cnt = w_cnt_inc;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_have  <= n_have;
        end
    end

endmodule

// ===== rtl/lirs_checker.sv =====
// port level checks for linear_interp_resampler_unit, attached by bind
// depends on linear_interp_resampler_unit_assert.svh
`include "linear_interp_resampler_unit_assert.svh"

module lirs_checker #(
    parameter int SAMPLE_BITS = 24,
    localparam int DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [DATA_BITS-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // a stalled result frame stays put
    `LIRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // an accepted frame makes the slave side busy in the next cycle
    `LIRS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // reset leaves nothing pending and the input open
    `LIRS_ASSERT_NEXT_ALWAYS(a_reset_clean, !i_rst_n, !m_axis_tvalid && s_axis_tready)

endmodule

bind linear_interp_resampler_unit lirs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lirs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb_linear_interp_resampler_unit.sv =====
`timescale 1ns / 100ps
// self-checking testbench for linear_interp_resampler_unit: stream frames in,
// interpolated frames out, compared with a local phase and lerp predictor
// depends on lirs_pkg and the linear_interp_resampler_unit rtl
module tb_linear_interp_resampler_unit
    import lirs_pkg::*;
();

    localparam int      TDATA_BITS    = ((2 * SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int      IDLE_LIMIT    = 2000;
    localparam int      SETTLE_CYCLES = 16;
    localparam int      HOLD_CYCLES   = 240;
    localparam int      RANDOM_FRAMES = 100;
    localparam longint Q_ONE         = 64'sd1 <<< FRAC_BITS;
    localparam longint Q_HALF        = 64'sd1 <<< (FRAC_BITS - 1);

    localparam logic [RATIO_BITS-1:0] RATIO_UNITY   = RATIO_RESET;
    localparam logic [RATIO_BITS-1:0] RATIO_QUARTER = 27'h0400000;
    localparam logic [RATIO_BITS-1:0] RATIO_EIGHTH  = 27'h0200000;
    localparam logic [RATIO_BITS-1:0] RATIO_3_HALF  = 27'h1800000;
    localparam logic [RATIO_BITS-1:0] RATIO_MAX     = 27'h7FFFFFF;

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] right;
        logic        last;
    } t_out_frame;

    // typed marks a row whose single output is written out by hand
    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio;
        logic                  mono;
        logic [23:0]           left;
        logic [23:0]           right;
        logic                  restart;
        logic                  typed;
        logic [23:0]           typed_l;
        logic [23:0]           typed_r;
    } t_stim_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [TDATA_BITS-1:0]    s_axis_tdata;    // sample_left, sample_right
    logic                     s_axis_tuser;    // restart
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [TDATA_BITS-1:0]    m_axis_tdata;    // out_left, out_right
    logic                     m_axis_tlast;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // predictor state and its copy of the registers
    logic [RATIO_BITS-1:0]        ratio_cfg = RATIO_RESET;
    logic                         mono_cfg  = 1'b0;
    logic signed [PHASE_BITS-1:0] phase_acc = '0;
    longint                       hist_l    = 0;
    longint                       hist_r    = 0;
    bit                           hist_valid = 1'b0;

    t_out_frame interp_out [MAX_UPSAMPLE_DEF];
    t_out_frame frames_due [$];
    t_out_frame due_frame;

    int error_count     = 0;
    int frames_in       = 0;
    int frames_expected = 0;
    int frames_seen     = 0;
    int config_writes   = 0;
    int idle_cycles     = 0;
    int src_gap_pct     = 0;
    int sink_stall_pct  = 0;
    bit hold_flip       = 1'b0;
    bit hold_seen       = 1'b0;
    int hold_left       = 0;

    t_stim_row directed_rows [25] = '{
        '{RATIO_UNITY,   1'b0, 24'h7FFFFF, 24'h800000, 1'b0, 1'b1, 24'h7FFFFF, 24'h800000},
        '{RATIO_UNITY,   1'b0, 24'h800000, 24'h7FFFFF, 1'b0, 1'b1, 24'h800000, 24'h7FFFFF},
        '{RATIO_UNITY,   1'b0, 24'h000000, 24'h000000, 1'b1, 1'b1, 24'h000000, 24'h000000},
        '{RATIO_UNITY,   1'b0, 24'hFFFFFF, 24'h000001, 1'b0, 1'b1, 24'hFFFFFF, 24'h000001},
        '{RATIO_UNITY,   1'b1, 24'h123456, 24'h654321, 1'b0, 1'b1, 24'h123456, 24'h123456},
        '{RATIO_UNITY,   1'b1, 24'h800000, 24'h7FFFFF, 1'b0, 1'b1, 24'h800000, 24'h800000},
        '{RATIO_QUARTER, 1'b0, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0, 24'h0, 24'h0},
        '{RATIO_QUARTER, 1'b0, 24'h800000, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_QUARTER, 1'b0, 24'h000001, 24'hFFFFFF, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_QUARTER, 1'b0, 24'h000002, 24'hFFFFFE, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_EIGHTH,  1'b0, 24'h400000, 24'hC00000, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_EIGHTH,  1'b0, 24'hC00000, 24'h400000, 1'b0, 1'b0, 24'h0, 24'h0},
        '{27'h0000000,   1'b0, 24'h7FFFFF, 24'h800000, 1'b0, 1'b0, 24'h0, 24'h0},
        '{27'h0000000,   1'b0, 24'h000010, 24'hFFFFF0, 1'b0, 1'b0, 24'h0, 24'h0},
        '{27'h0000003,   1'b0, 24'h800000, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_MAX,     1'b0, 24'h111111, 24'hEEEEEE, 1'b1, 1'b0, 24'h0, 24'h0},
        '{RATIO_MAX,     1'b0, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_MAX,     1'b0, 24'h800000, 24'h800000, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_MAX,     1'b0, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_MAX,     1'b0, 24'h555555, 24'hAAAAAA, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_3_HALF,  1'b1, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0, 24'h0, 24'h0},
        '{RATIO_3_HALF,  1'b1, 24'h800000, 24'h123456, 1'b0, 1'b0, 24'h0, 24'h0},
        '{RATIO_3_HALF,  1'b1, 24'h000001, 24'h000000, 1'b0, 1'b0, 24'h0, 24'h0},
        '{27'h1000001,   1'b0, 24'h7FFFFF, 24'h800000, 1'b1, 1'b0, 24'h0, 24'h0},
        '{27'h0FFFFFF,   1'b0, 24'h800000, 24'h7FFFFF, 1'b0, 1'b0, 24'h0, 24'h0}
    };

    linear_interp_resampler_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 50) begin
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        end
    endtask

    // one input frame: fills interp_out, returns the number of output frames
    function automatic int interp_frame(input logic [23:0] in_l, input logic [23:0] in_r,
                                        input logic restart);
        longint cur_l;
        longint cur_r;
        longint prev_l;
        longint prev_r;
        longint pos;
        longint frac;
        longint val_l;
        longint val_r;
        int     n;
        cur_l = longint'($signed(in_l));
        cur_r = mono_cfg ? cur_l : longint'($signed(in_r));
        if (restart) begin
            phase_acc  = '0;
            hist_l     = 0;
            hist_r     = 0;
            hist_valid = 1'b0;
        end
        pos    = phase_acc;
        prev_l = hist_valid ? hist_l : 0;
        prev_r = hist_valid ? hist_r : 0;
        n      = 0;
        while (n < MAX_UPSAMPLE_DEF && pos >= -Q_ONE && pos <= 0 && (pos == 0 || hist_valid)) begin
            if (pos == 0) begin
                val_l = cur_l;
                val_r = cur_r;
            end else begin
                frac  = pos + Q_ONE;
                val_l = prev_l + (((cur_l - prev_l) * frac + Q_HALF) >>> FRAC_BITS);
                val_r = prev_r + (((cur_r - prev_r) * frac + Q_HALF) >>> FRAC_BITS);
            end
            interp_out[n] = '{val_l[23:0], val_r[23:0], 1'b0};
            n++;
            pos += longint'(ratio_cfg);
        end
        if (n > 0) interp_out[n-1].last = 1'b1;
        // drop by one frame, never further back than the previous frame
        pos -= Q_ONE;
        if (pos < -Q_ONE) pos = -Q_ONE;
        phase_acc  = pos[31:0];
        hist_l     = cur_l;
        hist_r     = cur_r;
        hist_valid = 1'b1;
        return n;
    endfunction

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 16)) - 24'd8;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_frame(input logic [23:0] left, input logic [23:0] right,
                              input logic restart, input logic typed,
                              input logic [23:0] typed_l, input logic [23:0] typed_r);
        int n;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n = interp_frame(left, right, restart);
        frames_in++;
        if (typed) begin
            frames_due.push_back('{typed_l, typed_r, 1'b1});
            frames_expected++;
        end else begin
            for (int k = 0; k < n; k++) frames_due.push_back(interp_out[k]);
            frames_expected += n;
        end
    endtask

    // waits out every due frame plus the tail of a frame that gives none
    task automatic drain_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write_check(input logic [REG_IDX_BITS-1:0] idx,
                                   input logic [31:0] value, input logic [31:0] mask);
        logic [31:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        config_writes++;
        if ((rd & mask) != (value & mask)) report_mismatch("register read back", rd, value);
    endtask

    task automatic set_config(input logic [RATIO_BITS-1:0] ratio, input logic mono);
        drain_block();
        apb_write_check(REG_STEP_RATIO, 32'(ratio), 32'h07FF_FFFF);
        apb_write_check(REG_MONO_INPUT, 32'(mono), 32'h0000_0001);
        ratio_cfg = ratio;
        mono_cfg  = mono;
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_flip != hold_seen) begin
                hold_seen = hold_flip;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            frames_seen++;
            if (frames_due.size() == 0) begin
                report_mismatch("output frame with nothing due", 32'(m_axis_tdata[23:0]), 32'h0);
            end else begin
                due_frame = frames_due.pop_front();
                if (m_axis_tdata[23:0] != due_frame.left)
                    report_mismatch("out_left", 32'(m_axis_tdata[23:0]), 32'(due_frame.left));
                if (m_axis_tdata[47:24] != due_frame.right)
                    report_mismatch("out_right", 32'(m_axis_tdata[47:24]), 32'(due_frame.right));
                if (m_axis_tlast != due_frame.last)
                    report_mismatch("last_of_run", 32'(m_axis_tlast), 32'(due_frame.last));
            end
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [RATIO_BITS-1:0] ratio;
        logic                  mono;
        int                    random_frames;
        int                    stage;
        int                    seg_len;
        bit                    pressure_done;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        random_frames = 0;
        pressure_done = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_gap_pct    = 23;
        sink_stall_pct = 48;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].ratio != ratio_cfg || directed_rows[i].mono != mono_cfg)
                set_config(directed_rows[i].ratio, directed_rows[i].mono);
            send_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].restart,
                       directed_rows[i].typed, directed_rows[i].typed_l,
                       directed_rows[i].typed_r);
        end

        // random segments, each under its own ratio and channel mode
        while (random_frames < RANDOM_FRAMES) begin
            stage = (random_frames < RANDOM_FRAMES / 3) ? 0 :
                    (random_frames < 2 * RANDOM_FRAMES / 3) ? 1 : 2;
            src_gap_pct    = (stage == 0) ? 23 : (stage == 1) ? 48 : 0;
            sink_stall_pct = (stage == 0) ? 48 : (stage == 1) ? 23 : 0;
            case ($urandom_range(0, 5))
                0: ratio = RATIO_EIGHTH;
                1: ratio = RATIO_MAX;
                2: ratio = RATIO_BITS'($urandom_range(0, 7));
                3: ratio = RATIO_BITS'($urandom);
                default: ratio = RATIO_BITS'($urandom_range(32'h0200000, 32'h2000000));
            endcase
            mono = 1'($urandom_range(0, 1));
            if (stage == 2 && !pressure_done) ratio = RATIO_QUARTER;
            set_config(ratio, mono);
            if (stage == 2 && !pressure_done) begin
                hold_flip     = ~hold_flip;
                pressure_done = 1'b1;
            end
            seg_len = $urandom_range(6, 16);
            repeat (seg_len) begin
                send_frame(rand_sample(), rand_sample(), $urandom_range(0, 19) == 0,
                           1'b0, 24'h0, 24'h0);
                random_frames++;
            end
        end

        drain_block();
        if (frames_seen != frames_expected)
            report_mismatch("output frame count", 32'(frames_seen), 32'(frames_expected));
        $display("covered %0d input frames, %0d output frames, %0d register writes",
                 frames_in, frames_seen, config_writes);
        $display("ratios from zero to full scale, mono and stereo, restarts, long output stall");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lirs_pkg.sv
rtl/lirs_lane.sv
rtl/lirs_seq.sv
rtl/linear_interp_resampler_unit.sv
rtl/lirs_checker.sv
test/tb_linear_interp_resampler_unit.sv
